@@ hw/rtl/tftuv_pkg.sv @@
package tftuv_pkg;

    localparam int COORD_W   = 16;
    localparam int UV_W      = 16;
    localparam int POS_FRAC  = 8;
    localparam int UV_FRAC   = 15;
    localparam int AREA_W    = 48;
    localparam int DET_W     = 32;
    localparam int TAN_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int DIFF_W    = 17;
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int WIDE_W    = 35;
    localparam int BIG_BIT   = 24;
    localparam int SQ_W      = 50;
    localparam int DIV_SHIFT = UV_FRAC + POS_FRAC;
    localparam int DVD_W     = WIDE_W + DIV_SHIFT;
    localparam int Q_W       = TAN_W + 1;
    localparam int CNT_W     = $clog2(DVD_W);

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_LIMIT  = 2'd1;

    localparam logic [AREA_W-1:0] AREA_LIMIT_RST = 48'd42950;
    localparam logic [DET_W-1:0]  DET_LIMIT_RST  = 32'd11;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AREA = 2'd1;
    localparam logic [1:0] ST_DET  = 2'd2;

    localparam logic [TAN_W-1:0] TAN_MAX = 32'h7FFF_FFFF;
    localparam logic [TAN_W-1:0] TAN_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]                corner;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [UV_W-1:0]           tex_u;
        logic [UV_W-1:0]           tex_v;
    } t_in_item;

    typedef struct packed {
        logic signed [TAN_W-1:0] tangent_x;
        logic signed [TAN_W-1:0] tangent_y;
        logic signed [TAN_W-1:0] tangent_z;
        logic [1:0]              status;
    } t_out_item;

    function automatic logic [WIDE_W-1:0] f_abs(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] r;
        r = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        return r;
    endfunction

endpackage

@@ hw/rtl/tftuv_div.sv @@
module tftuv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tftuv_pkg::WIDE_W-1:0]  i_num,
    input  logic [tftuv_pkg::WIDE_W-1:0]  i_den,
    output logic                          o_done,
    output logic                          o_over,
    output logic [tftuv_pkg::Q_W-1:0]     o_quot
);
    import tftuv_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DVD_W-1:0]    r_dvd;
    logic [WIDE_W-1:0]   r_rem;
    logic [WIDE_W-1:0]   r_den;
    logic [Q_W-1:0]      r_q;
    logic                r_over;
    logic [WIDE_W:0]     trial;
    logic                ge;
    logic [WIDE_W:0]     rem_nx;

    assign trial  = {r_rem, r_dvd[DVD_W-1]};
    assign ge     = trial >= {1'b0, r_den};
    assign rem_nx = ge ? trial - {1'b0, r_den} : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {i_num, {DIV_SHIFT{1'b0}}};
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem  <= rem_nx[WIDE_W-1:0];
            r_q    <= {r_q[Q_W-2:0], ge};
            r_over <= r_over | r_q[Q_W-1];
        end
    end

    assign o_done = r_done;
    assign o_over = r_over;
    assign o_quot = r_q;

endmodule

@@ hw/rtl/triangle_tangent_from_uv_top.sv @@
// Corners 0 and 1 are stored when accepted; corner 3 is dropped.
// A degenerate triangle goes from corner 2 straight to the output; otherwise
// the result waits on three restoring divides at one quotient bit per cycle.
// The block stalls its input while a triangle is in progress.
// Reset is synchronous and active low; it clears stored corners 0 and 1 and
// loads the default limits.
module triangle_tangent_from_uv_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tftuv_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tftuv_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tftuv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tftuv_pkg::AREA_W-1:0]        i_cfg_data
);
    import tftuv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_NUM    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                r_state;
    logic [3:0]                r_step;
    logic [1:0]                r_comp;
    logic [AREA_W-1:0]         r_area;
    logic [DET_W-1:0]          r_det_lim;
    logic signed [COORD_W-1:0] r_p0 [3];
    logic signed [COORD_W-1:0] r_p1 [3];
    logic signed [COORD_W-1:0] r_p2 [3];
    logic [UV_W-1:0]           r_t0 [2];
    logic [UV_W-1:0]           r_t1 [2];
    logic [UV_W-1:0]           r_t2 [2];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [WIDE_W-1:0]  r_acc;
    logic signed [WIDE_W-1:0]  r_cx, r_cy, r_cz, r_det;
    logic [WIDE_W-1:0]         r_adet;
    logic [SQ_W-1:0]           r_sq;
    logic                      r_num_neg;
    logic [TAN_W-1:0]          r_tan [3];
    logic [1:0]                r_status;
    logic                      r_ovld;
    t_out_item                 r_odata;

    logic signed [DIFF_W-1:0]  e0 [3];
    logic signed [DIFF_W-1:0]  e1 [3];
    logic signed [DIFF_W-1:0]  ua, ub, uc, ud;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [WIDE_W-1:0]  diff;
    logic                      big_x, big_y, big_z, big;
    logic [WIDE_W-1:0]         adet;
    logic                      in_acc;
    logic                      div_start;
    logic                      div_done;
    logic                      div_over;
    logic [Q_W-1:0]            quot;
    logic                      neg;
    logic [TAN_W-1:0]          tan_val;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e0[i] = DIFF_W'(r_p1[i]) - DIFF_W'(r_p0[i]);
            e1[i] = DIFF_W'(r_p2[i]) - DIFF_W'(r_p0[i]);
        end
    end

    assign ua = $signed({1'b0, r_t1[0]}) - $signed({1'b0, r_t0[0]});
    assign ub = $signed({1'b0, r_t1[1]}) - $signed({1'b0, r_t0[1]});
    assign uc = $signed({1'b0, r_t2[0]}) - $signed({1'b0, r_t0[0]});
    assign ud = $signed({1'b0, r_t2[1]}) - $signed({1'b0, r_t0[1]});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                4'd0:    begin mul_a = MUL_W'(e0[1]); mul_b = MUL_W'(e1[2]); end
                4'd1:    begin mul_a = MUL_W'(e0[2]); mul_b = MUL_W'(e1[1]); end
                4'd2:    begin mul_a = MUL_W'(e0[2]); mul_b = MUL_W'(e1[0]); end
                4'd3:    begin mul_a = MUL_W'(e0[0]); mul_b = MUL_W'(e1[2]); end
                4'd4:    begin mul_a = MUL_W'(e0[0]); mul_b = MUL_W'(e1[1]); end
                4'd5:    begin mul_a = MUL_W'(e0[1]); mul_b = MUL_W'(e1[0]); end
                4'd6:    begin mul_a = MUL_W'(ua); mul_b = MUL_W'(ud); end
                4'd7:    begin mul_a = MUL_W'(ub); mul_b = MUL_W'(uc); end
                4'd8:    begin mul_a = $signed(r_cx[MUL_W-1:0]); mul_b = $signed(r_cx[MUL_W-1:0]); end
                4'd9:    begin mul_a = $signed(r_cy[MUL_W-1:0]); mul_b = $signed(r_cy[MUL_W-1:0]); end
                4'd10:   begin mul_a = $signed(r_cz[MUL_W-1:0]); mul_b = $signed(r_cz[MUL_W-1:0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_NUM) begin
            if (r_step == 4'd0) begin
                mul_a = MUL_W'(e0[r_comp]);
                mul_b = MUL_W'(ud);
            end else begin
                mul_a = MUL_W'(e1[r_comp]);
                mul_b = MUL_W'(ub);
            end
        end
    end

    assign diff  = r_acc - $signed(r_prod[WIDE_W-1:0]);
    assign big_x = f_abs(r_cx) >= (WIDE_W'(1) << BIG_BIT);
    assign big_y = f_abs(r_cy) >= (WIDE_W'(1) << BIG_BIT);
    assign big_z = f_abs(r_cz) >= (WIDE_W'(1) << BIG_BIT);
    assign big   = big_x | big_y | big_z;
    assign adet  = f_abs(r_det);

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign div_start   = (r_state == S_NUM) && (r_step == 4'd2);

    tftuv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (f_abs(diff)),
        .i_den   (r_adet),
        .o_done  (div_done),
        .o_over  (div_over),
        .o_quot  (quot)
    );

    assign neg = r_num_neg ^ r_det[WIDE_W-1];

    always_comb begin
        if (neg) begin
            if (div_over || quot[Q_W-1] || quot[TAN_W-1]) begin
                tan_val = TAN_MIN;
            end else begin
                tan_val = TAN_W'(-quot[TAN_W-1:0]);
            end
        end else begin
            if (div_over || quot[Q_W-1] || (quot[TAN_W-1:0] >= TAN_MAX)) begin
                tan_val = TAN_MAX;
            end else begin
                tan_val = quot[TAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area    <= AREA_LIMIT_RST;
            r_det_lim <= DET_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_AREA_LIMIT) begin
                r_area <= i_cfg_data;
            end else if (i_cfg_index == CFG_DET_LIMIT) begin
                r_det_lim <= i_cfg_data[DET_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_p0[i] <= '0;
                r_p1[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_t0[i] <= '0;
                r_t1[i] <= '0;
            end
        end else if (in_acc) begin
            if (i_in_data.corner == CORNER_0) begin
                r_p0[0] <= i_in_data.pos_x;
                r_p0[1] <= i_in_data.pos_y;
                r_p0[2] <= i_in_data.pos_z;
                r_t0[0] <= i_in_data.tex_u;
                r_t0[1] <= i_in_data.tex_v;
            end else if (i_in_data.corner == CORNER_1) begin
                r_p1[0] <= i_in_data.pos_x;
                r_p1[1] <= i_in_data.pos_y;
                r_p1[2] <= i_in_data.pos_z;
                r_t1[0] <= i_in_data.tex_u;
                r_t1[1] <= i_in_data.tex_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.corner == CORNER_2) begin
            r_p2[0] <= i_in_data.pos_x;
            r_p2[1] <= i_in_data.pos_y;
            r_p2[2] <= i_in_data.pos_z;
            r_t2[0] <= i_in_data.tex_u;
            r_t2[1] <= i_in_data.tex_v;
        end
        r_prod <= mul_a * mul_b;
        if (r_state == S_MUL) begin
            case (r_step) inside
                4'd1, 4'd3, 4'd5, 4'd7: r_acc <= $signed(r_prod[WIDE_W-1:0]);
                4'd2:    r_cx  <= diff;
                4'd4:    r_cy  <= diff;
                4'd6:    r_cz  <= diff;
                4'd8:    r_det <= diff;
                4'd9:    r_sq  <= big_x ? '0 : SQ_W'(r_prod[2*BIG_BIT-1:0]);
                4'd10:   r_sq  <= r_sq + (big_y ? '0 : SQ_W'(r_prod[2*BIG_BIT-1:0]));
                4'd11:   r_sq  <= r_sq + (big_z ? '0 : SQ_W'(r_prod[2*BIG_BIT-1:0]));
                default: r_acc <= r_acc;
            endcase
        end else if (r_state == S_NUM) begin
            if (r_step == 4'd1) begin
                r_acc <= $signed(r_prod[WIDE_W-1:0]);
            end else if (r_step == 4'd2) begin
                r_num_neg <= diff[WIDE_W-1];
            end
        end
        if (r_state == S_DECIDE) begin
            r_adet <= adet;
            if (!big && (r_sq < SQ_W'(r_area))) begin
                r_status <= ST_AREA;
            end else if ((adet == '0) || (adet < WIDE_W'(r_det_lim))) begin
                r_status <= ST_DET;
            end else begin
                r_status <= ST_OK;
            end
            for (int i = 0; i < 3; i++) begin
                r_tan[i] <= '0;
            end
        end
        if (r_state == S_DIV && div_done) begin
            r_tan[r_comp] <= tan_val;
        end
        if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
            r_odata.tangent_x <= r_tan[0];
            r_odata.tangent_y <= r_tan[1];
            r_odata.tangent_z <= r_tan[2];
            r_odata.status    <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_comp  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_comp <= '0;
                    if (in_acc && i_in_data.corner == CORNER_2) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd11) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_step <= '0;
                    if ((!big && (r_sq < SQ_W'(r_area))) || (adet == '0)
                        || (adet < WIDE_W'(r_det_lim))) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd2) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= '0;
                    if (div_done) begin
                        if (r_comp == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= S_NUM;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.tangent_x == '0 && o_out_data.tangent_y == '0
         && o_out_data.tangent_z == '0))
        else $error("degenerate result carries a nonzero tangent");

    a_corner2_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.corner == CORNER_2) |=> (r_state == S_MUL))
        else $error("corner 2 did not start the computation");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_AREA
                         || o_out_data.status == ST_DET))
        else $error("undefined status code on the output");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tftuv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASE_BEATS    = 80;
    localparam logic [1:0] CORNER_SKIP = 2'd3;

    typedef struct {
        t_in_item  beat;
        bit        typed;
        t_out_item tangent;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [AREA_W-1:0]    i_cfg_data = '0;

    triangle_tangent_from_uv_top dut (.*);

    always #6 i_clk = ~i_clk;

    longint          corner0_pos[3], corner1_pos[3], corner0_uv[2], corner1_uv[2];
    longint unsigned area_lim = AREA_LIMIT_RST;
    longint unsigned det_lim  = DET_LIMIT_RST;
    t_out_item       pending_tangents[$];
    int              fails = 0;
    bit              hold_req = 1'b0;
    bit              hold_taken = 1'b0;
    int              hold_cnt = 0;
    int              busy_cnt = 0;
    int              phase_cnt = 0;
    int              idle_cycles = 0;
    t_row            rows[$];

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    task automatic tangent_predict(input t_in_item it);
        longint          p[3], uv[2], e0[3], e1[3], cr[3], a, b, c, d, det, num;
        longint unsigned sq, adet, mn, q;
        logic [31:0]     tv[3];
        t_out_item       r;
        bit              big;
        p[0] = longint'(it.pos_x);
        p[1] = longint'(it.pos_y);
        p[2] = longint'(it.pos_z);
        uv[0] = longint'(it.tex_u);
        uv[1] = longint'(it.tex_v);
        case (it.corner)
            CORNER_0: begin
                corner0_pos = p;
                corner0_uv = uv;
            end
            CORNER_1: begin
                corner1_pos = p;
                corner1_uv = uv;
            end
            CORNER_2: begin
                r = '0;
                sq = 0;
                big = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    e0[i] = corner1_pos[i] - corner0_pos[i];
                    e1[i] = p[i] - corner0_pos[i];
                end
                cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
                cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
                cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
                for (int i = 0; i < 3; i++) begin
                    if (abs64(cr[i]) >= (64'd1 << 24)) big = 1'b1;
                    else sq += abs64(cr[i]) * abs64(cr[i]);
                end
                a = corner1_uv[0] - corner0_uv[0];
                b = corner1_uv[1] - corner0_uv[1];
                c = uv[0] - corner0_uv[0];
                d = uv[1] - corner0_uv[1];
                det = a * d - b * c;
                adet = abs64(det);
                if (!big && sq < area_lim) begin
                    r.status = ST_AREA;
                end else if (adet == 0 || adet < det_lim) begin
                    r.status = ST_DET;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        num = e0[i] * d - e1[i] * b;
                        mn = abs64(num);
                        q = (mn << DIV_SHIFT) / adet;
                        if ((num < 0) != (det < 0))
                            tv[i] = q >= 64'h8000_0000 ? TAN_MIN : 32'(-q);
                        else
                            tv[i] = q >= 64'h7FFF_FFFF ? TAN_MAX : 32'(q);
                    end
                    r.tangent_x = tv[0];
                    r.tangent_y = tv[1];
                    r.tangent_z = tv[2];
                    r.status = ST_OK;
                end
                pending_tangents = {pending_tangents, r};
            end
            default: ;
        endcase
    endtask

    // Accept one beat; the predictor only sees beats the block has taken.
    task automatic send_vertex(input t_in_item it, input bit no_gap, input bit typed,
                               input t_out_item tangent);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = (no_gap || r < 65) ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) begin
            pending_tangents = {pending_tangents, tangent};
        end else begin
            tangent_predict(it);
        end
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= AREA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_AREA_LIMIT) area_lim = val & 64'hFFFF_FFFF_FFFF;
        else if (idx == CFG_DET_LIMIT) det_lim = val & 64'hFFFF_FFFF;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_tangents.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item vertex(logic [1:0] cn, int x, int y, int z, int u, int v);
        t_in_item it;
        it.corner = cn;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.pos_z = 16'(z);
        it.tex_u = 16'(u);
        it.tex_v = 16'(v);
        return it;
    endfunction

    function automatic t_in_item random_vertex(logic [1:0] cn);
        t_in_item it;
        it = vertex(cn, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0) begin
            it.pos_x = 16'($signed($urandom_range(0, 255)) - 128);
            it.pos_y = 16'($signed($urandom_range(0, 255)) - 128);
            it.pos_z = 16'($signed($urandom_range(0, 255)) - 128);
        end
        if ($urandom_range(0, 3) == 0) begin
            it.tex_u = 16'($urandom_range(16000, 16063));
            it.tex_v = 16'($urandom_range(16000, 16063));
        end
        return it;
    endfunction

    function automatic void add_row(t_in_item it, bit typed = 1'b0, logic [1:0] st = ST_OK);
        t_row row;
        row.beat = it;
        row.typed = typed;
        row.tangent = '0;
        row.tangent.status = st;
        rows = {rows, row};
    endfunction

    always @(posedge i_clk) begin
        phase_cnt <= phase_cnt + 1;
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (phase_cnt[8]) begin
            i_out_stall <= 1'b0;
        end else if (busy_cnt > 0) begin
            busy_cnt <= busy_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_out_stall <= 1'b0;
            end else begin
                busy_cnt <= r < 95 ? $urandom_range(0, 2) : $urandom_range(10, 40);
                i_out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_tangents.size() == 0) begin
                $error("unexpected tangent beat %p", o_out_data);
                fails++;
            end else begin
                t_out_item e;
                e = pending_tangents.pop_front();
                if (o_out_data.tangent_x !== e.tangent_x) begin
                    $error("tangent_x expected %0d actual %0d", e.tangent_x, o_out_data.tangent_x);
                    fails++;
                end
                if (o_out_data.tangent_y !== e.tangent_y) begin
                    $error("tangent_y expected %0d actual %0d", e.tangent_y, o_out_data.tangent_y);
                    fails++;
                end
                if (o_out_data.tangent_z !== e.tangent_z) begin
                    $error("tangent_z expected %0d actual %0d", e.tangent_z, o_out_data.tangent_z);
                    fails++;
                end
                if (o_out_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_out_data.status);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n;
        t_out_item none;
        none = '0;
        for (int i = 0; i < 3; i++) begin
            corner0_pos[i] = 0;
            corner1_pos[i] = 0;
        end
        for (int i = 0; i < 2; i++) begin
            corner0_uv[i] = 0;
            corner1_uv[i] = 0;
        end

        add_row(vertex(CORNER_2, 0, 0, 0, 0, 0), 1'b1, ST_AREA);
        add_row(vertex(CORNER_SKIP, -1, -1, -1, 16'hFFFF, 16'hFFFF));
        add_row(vertex(CORNER_0, 0, 0, 0, 0, 0));
        add_row(vertex(CORNER_1, 256, 0, 0, 16'h4000, 0));
        add_row(vertex(CORNER_2, 0, 256, 0, 0, 16'h4000));
        add_row(vertex(CORNER_0, -32768, -32768, -32768, 0, 0));
        add_row(vertex(CORNER_1, 32767, 32767, 32767, 16'hFFFF, 16'hFFFF));
        add_row(vertex(CORNER_2, 32767, -32768, 32767, 0, 16'hFFFF));
        add_row(vertex(CORNER_0, 0, 0, 0, 100, 100));
        add_row(vertex(CORNER_1, 256, 0, 0, 200, 200));
        add_row(vertex(CORNER_2, 0, 256, 0, 300, 300), 1'b1, ST_DET);
        add_row(vertex(CORNER_0, 0, 0, 0, 0, 0));
        add_row(vertex(CORNER_1, 256, 256, 256, 10, 0));
        add_row(vertex(CORNER_2, 512, 512, 512, 0, 10), 1'b1, ST_AREA);
        add_row(vertex(CORNER_0, 5, 5, 5, 7, 7));
        add_row(vertex(CORNER_0, 0, 0, 0, 0, 0));
        add_row(vertex(CORNER_1, 1000, 1000, 1000, 1, 1));
        add_row(vertex(CORNER_1, -32768, 100, 0, 4, 0));
        add_row(vertex(CORNER_2, 0, -32768, 32767, 0, 4));
        add_row(vertex(CORNER_2, 32767, 32767, -32768, 0, 4));
        add_row(vertex(CORNER_2, 0, 0, 256, 3, 1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_vertex(rows[k].beat, 1'b0, rows[k].typed, rows[k].tangent);

        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            case (phase)
                1: begin
                    write_limit(CFG_AREA_LIMIT, 0);
                    write_limit(CFG_DET_LIMIT, 0);
                end
                2: begin
                    write_limit(CFG_AREA_LIMIT, 64'hFFFF_FFFF_FFFF);
                    write_limit(CFG_DET_LIMIT, 64'hFFFF_FFFF);
                end
                3: begin
                    write_limit(CFG_AREA_LIMIT, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
                    write_limit(CFG_DET_LIMIT, $urandom_range(0, 1 << 20));
                end
                4: begin
                    write_limit(CFG_AREA_LIMIT, AREA_LIMIT_RST);
                    write_limit(CFG_DET_LIMIT, DET_LIMIT_RST);
                end
                default: ;
            endcase
            n = 0;
            while (n < PHASE_BEATS) begin
                if (phase == 4 && n == 20) hold_req = 1'b1;
                if ($urandom_range(0, 9) < 8) begin
                    for (int cn = 0; cn < 3; cn++)
                        send_vertex(random_vertex(2'(cn)), hold_req, 1'b0, none);
                    n += 3;
                end else begin
                    t_in_item it;
                    it = random_vertex(2'($urandom_range(0, 3)));
                    send_vertex(it, hold_req, 1'b0, none);
                    if (it.corner != CORNER_SKIP) n++;
                end
            end
        end

        drain_results();
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ triangle_tangent_from_uv_top.f @@
hw/rtl/tftuv_pkg.sv
hw/rtl/tftuv_div.sv
hw/rtl/triangle_tangent_from_uv_top.sv
sim/tb_top.sv
